// File: sv/wcp_pkg.sv
package wcp_pkg;

  localparam int COLUMNS_DEF = 128;
  localparam int COL_W       = 7;
  localparam int SAMPLE_W    = 10;
  localparam int ROW_W       = 6;
  localparam int SHIFT_W     = 5;
  localparam int SCALE_W     = 4;
  localparam int NORM_W      = 16;
  localparam int NORM_PAD    = NORM_W - SAMPLE_W;

  localparam logic [7:0]         PAGE_BASE  = 8'hB8;
  localparam logic [7:0]         COL_BASE   = 8'h40;
  localparam logic [7:0]         DATA_TOP   = 8'h80;
  localparam logic [7:0]         DATA_CLEAR = 8'h00;
  localparam logic [NORM_W-1:0]  RANGE_TOP  = 16'h8000;
  localparam logic [ROW_W-1:0]   ROW_MAX    = 6'd63;
  localparam logic [SHIFT_W-1:0] AUTO_START = 5'd4;

  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;
  localparam logic RS_COMMAND = 1'b0;
  localparam logic RS_DATA    = 1'b1;

  typedef struct packed {
    logic                command;
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] frame_min;
    logic [SAMPLE_W-1:0] frame_max;
    logic                fresh;
  } in_item_t;

  typedef struct packed {
    logic       chip_right;
    logic       reg_select;
    logic [7:0] bus_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic             chip_right;
    logic [5:0]       col;
    logic [ROW_W-1:0] cur_row;
    logic [ROW_W-1:0] prev_row;
    logic             col_cmd;
    logic             erase;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_NORM,
    F_EVAL
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PAGE,
    B_COL,
    B_DATA,
    B_EPAGE,
    B_ECOL,
    B_EDATA
  } back_state_t;

  function automatic logic [7:0] page_byte(input logic [ROW_W-1:0] row);
    return PAGE_BASE | {5'd0, ~row[5:3]};
  endfunction

  function automatic logic [7:0] col_byte(input logic [5:0] col);
    return COL_BASE | {2'd0, col};
  endfunction

  function automatic logic [7:0] data_byte(input logic [ROW_W-1:0] row);
    return DATA_TOP >> row[2:0];
  endfunction

endpackage

// File: sv/waveform_column_plotter_unit.sv
// Channel  Direction  Handshake             Payload
// input    in         in_push / in_full     in_item (command, sample, frame_min, frame_max, fresh)
// result   out        out_pop / out_empty   out_item (chip_right, reg_select, bus_byte, last)
// config   in         cfg_valid / cfg_ready cfg_scale_mode
//
// A sample item reads the stored row when taken; F_EVAL then computes the new row and
// queues a transfer job unless the row is unchanged in a non-fresh frame, waiting while
// the job queue is full. The result side then delivers one transfer per cycle while out_pop
// takes it, up to six, once B_IDLE has fetched the job from the queue. A header item is
// done at once with a fixed scale; in auto mode the range normalization shifts one bit per cycle.
// Reset is synchronous and clears the stored rows through one valid bit per column.
// A full job queue stalls the input; a stalled result stalls the output and can fill the queue.
module waveform_column_plotter_unit #(
  parameter int COLUMNS = wcp_pkg::COLUMNS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  wcp_pkg::in_item_t                  in_item,
  output logic                               out_empty,
  input  logic                               out_pop,
  output wcp_pkg::out_item_t                 out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic signed [wcp_pkg::SCALE_W-1:0] cfg_scale_mode
);
  import wcp_pkg::*;

  logic job_push, job_full, job_pop, job_empty;
  job_t job_wdata, job_rdata;

  wcp_front #(
    .COLUMNS(COLUMNS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_item        (in_item),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_scale_mode (cfg_scale_mode),
    .job_push       (job_push),
    .job_full       (job_full),
    .job_data       (job_wdata)
  );

  wcp_job_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .full  (job_full),
    .wdata (job_wdata),
    .pop   (job_pop),
    .empty (job_empty),
    .rdata (job_rdata)
  );

  wcp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .job_data  (job_rdata),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// File: sv/wcp_front.sv
module wcp_front #(
  parameter int COLUMNS = wcp_pkg::COLUMNS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  wcp_pkg::in_item_t                     in_item,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic signed [wcp_pkg::SCALE_W-1:0]    cfg_scale_mode,
  output logic                                  job_push,
  input  logic                                  job_full,
  output wcp_pkg::job_t                         job_data
);
  import wcp_pkg::*;

  localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
  localparam logic [COL_W-1:0] HALF_COL = COL_W'(64);
  localparam logic signed [SHIFT_W-1:0] FIX_POS_BASE = 5'sd5;
  localparam logic signed [SHIFT_W-1:0] FIX_NEG_BASE = 5'sd4;
  localparam int WIDE_W = SAMPLE_W + 12;

  front_state_t state_r, state_nxt;
  logic signed [SCALE_W-1:0] scale_r, scale_nxt;
  logic [COL_W-1:0] column_r, column_nxt;
  logic signed [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [SAMPLE_W-1:0] min_r, min_nxt;
  logic fresh_r, fresh_nxt;
  logic need_col_r, need_col_nxt;
  logic [NORM_W-1:0] mx_r, mx_nxt, mn_r, mn_nxt;
  logic signed [SAMPLE_W:0] d_r, d_nxt;
  logic [COLUMNS-1:0] valid_r;
  logic [ROW_W-1:0] mem [COLUMNS];
  logic [ROW_W-1:0] rd_row_r;
  logic rd_valid_r;

  logic acc, mem_we;
  logic [AW-1:0] col_idx;
  logic signed [SHIFT_W-1:0] scale_ext;
  logic [SHIFT_W-1:0] k_left;
  logic [SAMPLE_W-1:0] d_mag, v_right;
  logic [WIDE_W-1:0] v_left;
  logic [ROW_W-1:0] cur_row, prev_row;
  logic unchanged;
  logic [NORM_W-1:0] diff;

  assign col_idx   = column_r[AW-1:0];
  assign in_full   = (state_r != F_IDLE);
  assign cfg_ready = 1'b1;
  assign acc       = in_push && (state_r == F_IDLE);
  assign scale_ext = {scale_r[SCALE_W-1], scale_r};

  assign d_mag   = d_r[SAMPLE_W-1:0];
  assign k_left  = -shift_r;
  assign v_left  = {{(WIDE_W-SAMPLE_W){1'b0}}, d_mag} << k_left;
  assign v_right = d_mag >> shift_r[SHIFT_W-1:0];
  assign diff    = mx_r - mn_r;

  always_comb begin
    if (d_r < 0) begin
      cur_row = ROW_MAX;
    end else if (shift_r < 0) begin
      cur_row = (v_left > WIDE_W'(ROW_MAX)) ? ROW_MAX : v_left[ROW_W-1:0];
    end else begin
      cur_row = (v_right > SAMPLE_W'(ROW_MAX)) ? ROW_MAX : v_right[ROW_W-1:0];
    end
  end

  assign prev_row  = rd_valid_r ? rd_row_r : '0;
  assign unchanged = (cur_row == prev_row) && !fresh_r;

  always_comb begin
    job_data.chip_right = column_r[COL_W-1];
    job_data.col        = column_r[5:0];
    job_data.cur_row    = cur_row;
    job_data.prev_row   = prev_row;
    job_data.col_cmd    = need_col_r || (column_r == HALF_COL);
    job_data.erase      = (cur_row[5:3] != prev_row[5:3]) && !fresh_r;
  end

  always_comb begin
    state_nxt    = state_r;
    scale_nxt    = scale_r;
    column_nxt   = column_r;
    shift_nxt    = shift_r;
    min_nxt      = min_r;
    fresh_nxt    = fresh_r;
    need_col_nxt = need_col_r;
    mx_nxt       = mx_r;
    mn_nxt       = mn_r;
    d_nxt        = d_r;
    job_push     = 1'b0;
    mem_we       = 1'b0;
    if (cfg_valid) begin
      scale_nxt = cfg_scale_mode;
    end
    case (state_r)
      F_IDLE: begin
        if (acc) begin
          d_nxt = $signed({1'b0, in_item.sample}) - $signed({1'b0, min_r});
          if (in_item.command == CMD_SAMPLE) begin
            state_nxt = F_EVAL;
          end else begin
            fresh_nxt    = in_item.fresh;
            column_nxt   = '0;
            need_col_nxt = 1'b1;
            if (scale_r == 0) begin
              mx_nxt    = {in_item.frame_max, {NORM_PAD{1'b0}}};
              mn_nxt    = {in_item.frame_min, {NORM_PAD{1'b0}}};
              shift_nxt = AUTO_START;
              min_nxt   = in_item.frame_min;
              state_nxt = F_NORM;
            end else begin
              shift_nxt = (scale_r > 0) ? (FIX_POS_BASE - scale_ext)
                                        : (FIX_NEG_BASE - scale_ext);
              min_nxt   = '0;
            end
          end
        end
      end
      F_NORM: begin
        if (((diff & RANGE_TOP) != '0) || (mx_r == '0)) begin
          state_nxt = F_IDLE;
        end else begin
          mx_nxt    = mx_r << 1;
          mn_nxt    = mn_r << 1;
          shift_nxt = shift_r - 5'sd1;
        end
      end
      F_EVAL: begin
        if (!job_full) begin
          job_push     = !unchanged;
          mem_we       = 1'b1;
          need_col_nxt = unchanged;
          state_nxt    = F_IDLE;
          if (column_r >= LAST_COL) begin
            column_nxt   = '0;
            fresh_nxt    = 1'b0;
            need_col_nxt = 1'b1;
          end else begin
            column_nxt = column_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      scale_r    <= '0;
      column_r   <= '0;
      shift_r    <= '0;
      min_r      <= '0;
      fresh_r    <= 1'b1;
      need_col_r <= 1'b1;
      valid_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      scale_r    <= scale_nxt;
      column_r   <= column_nxt;
      shift_r    <= shift_nxt;
      min_r      <= min_nxt;
      fresh_r    <= fresh_nxt;
      need_col_r <= need_col_nxt;
      if (mem_we) begin
        valid_r[col_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mx_r <= mx_nxt;
    mn_r <= mn_nxt;
    d_r  <= d_nxt;
    if (mem_we) begin
      mem[col_idx] <= cur_row;
    end
    if (acc) begin
      rd_row_r   <= mem[col_idx];
      rd_valid_r <= valid_r[col_idx];
    end
  end

endmodule

// File: sv/wcp_job_queue.sv
module wcp_job_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  wcp_pkg::job_t wdata,
  input  logic          pop,
  output logic          empty,
  output wcp_pkg::job_t rdata
);
  import wcp_pkg::*;

  localparam int DEPTH = 2;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t slot_r [DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic wp_r, rp_r;
  logic do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rp_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= wdata;
    end
  end

endmodule

// File: sv/wcp_back.sv
module wcp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_empty,
  output logic               job_pop,
  input  wcp_pkg::job_t      job_data,
  output logic               out_empty,
  input  logic               out_pop,
  output wcp_pkg::out_item_t out_item
);
  import wcp_pkg::*;

  back_state_t state_r, state_nxt;
  job_t job_r, job_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;
  logic load;

  assign out_empty = !out_valid_r;
  assign out_item  = out_r;
  assign load      = !out_valid_r || out_pop;

  always_comb begin
    state_nxt          = state_r;
    job_nxt            = job_r;
    out_valid_nxt      = out_valid_r && !out_pop;
    out_nxt            = out_r;
    job_pop            = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!job_empty) begin
          job_pop   = 1'b1;
          job_nxt   = job_data;
          state_nxt = B_PAGE;
        end
      end
      B_PAGE: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{job_r.chip_right, RS_COMMAND, page_byte(job_r.cur_row), 1'b0};
          state_nxt     = job_r.col_cmd ? B_COL : B_DATA;
        end
      end
      B_COL: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{job_r.chip_right, RS_COMMAND, col_byte(job_r.col), 1'b0};
          state_nxt     = B_DATA;
        end
      end
      B_DATA: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{job_r.chip_right, RS_DATA, data_byte(job_r.cur_row),
                            !job_r.erase};
          state_nxt     = job_r.erase ? B_EPAGE : B_IDLE;
        end
      end
      B_EPAGE: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{job_r.chip_right, RS_COMMAND, page_byte(job_r.prev_row), 1'b0};
          state_nxt     = B_ECOL;
        end
      end
      B_ECOL: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{job_r.chip_right, RS_COMMAND, col_byte(job_r.col), 1'b0};
          state_nxt     = B_EDATA;
        end
      end
      B_EDATA: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{job_r.chip_right, RS_DATA, DATA_CLEAR, 1'b1};
          state_nxt     = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    out_r <= out_nxt;
  end

endmodule

// File: sv/wcp_checker.sv
module wcp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_push,
  input logic               in_full,
  input wcp_pkg::in_item_t  in_item,
  input logic               out_empty,
  input logic               out_pop,
  input wcp_pkg::out_item_t out_item
);
  import wcp_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full && (in_item.command == CMD_SAMPLE) |=> in_full)
    else $error("input taken again right after a sample transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("waiting result changed before its transaction");

  a_data_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && (out_item.reg_select == RS_DATA) |-> $onehot0(out_item.bus_byte))
    else $error("data byte sets more than one pixel");

  a_cmd_form: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && (out_item.reg_select == RS_COMMAND) |->
      (out_item.bus_byte[7:3] == 5'b10111) || (out_item.bus_byte[7:6] == 2'b01))
    else $error("command byte is neither a page nor a column command");

endmodule

bind waveform_column_plotter_unit wcp_checker u_wcp_checker (.*);
